>>> rtl/core/mrwt_pkg.sv
// Shared types for the Miller-Rabin witness test block.
`timescale 1ns / 1ps

package mrwt_pkg;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_status_t;

endpackage

>>> rtl/core/mrwt_modmul.sv
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module mrwt_modmul
    import mrwt_pkg::*;
#(
    parameter int W = 31
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] x,
    input  logic [W-1:0] y,
    input  logic [W-1:0] n,
    output mul_status_t  status,
    output logic [W-1:0] result
);

    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     acc_reg;
    logic [W-1:0]     x_reg;
    logic [W-1:0]     y_reg;
    logic [W-1:0]     n_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;

    logic [W+1:0] sum;
    logic [W+2:0] sum_ext;
    logic [W+2:0] diff1;
    logic [W+2:0] diff2;
    logic [W-1:0] acc_next;

    always_comb
    begin
        sum = {1'b0, acc_reg, 1'b0} + {2'b00, (y_reg[W-1] ? x_reg : '0)};
        sum_ext = {1'b0, sum};
        diff1 = sum_ext - {3'b000, n_reg};
        diff2 = sum_ext - {2'b00, n_reg, 1'b0};
        if (!diff2[W+2])
        begin
            acc_next = diff2[W-1:0];
        end
        else if (!diff1[W+2])
        begin
            acc_next = diff1[W-1:0];
        end
        else
        begin
            acc_next = sum[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            n_reg    <= '0;
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                acc_reg <= '0;
                x_reg   <= x;
                y_reg   <= y;
                n_reg   <= n;
                cnt_reg <= CNT_W'(W - 1);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                acc_reg <= acc_next;
                y_reg   <= {y_reg[W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign status.busy = run_reg;
    assign status.done = done_reg;
    assign result      = acc_reg;

endmodule

>>> rtl/core/miller_rabin_witness_test_top.sv
// Top level of the Miller-Rabin witness test for one candidate and one base.
`timescale 1ns / 1ps

// Each transfer tests one candidate against one witness base and produces one
// verdict, shown on probably_prime and decided_trivially for a single cycle
// marked by done. Even candidates and the candidates one and three are decided
// at once, with the result in the cycle after the transfer. Every other
// candidate goes through a single bit-serial modular multiplier: S_STRIP splits
// n - 1 into t times 2^s, one product reduces the base, then one squaring per
// exponent bit plus one multiply per set bit of t (with an S_NEXT step per
// bit), and up to s - 1 final squarings. The block takes no new item while
// busy is high, and the receiver must take each result in the cycle in which
// done is high.

module miller_rabin_witness_test_top
    import mrwt_pkg::*;
#(
    parameter int NUM_WIDTH = 31
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [NUM_WIDTH-1:0] candidate,
    input  logic [NUM_WIDTH-1:0] witness_base,
    output logic                 done,
    output logic                 probably_prime,
    output logic                 decided_trivially
);

    localparam int W     = NUM_WIDTH;
    localparam int CNT_W = $clog2(W + 1);
    localparam int S_W   = $clog2(W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STRIP,
        S_RED,
        S_SQ,
        S_MB,
        S_NEXT,
        S_CHK,
        S_LSQ
    } state_t;

    localparam logic [W-1:0] ONE   = W'(1);
    localparam logic [W-1:0] TWO   = W'(2);
    localparam logic [W-1:0] THREE = W'(3);

    state_t           state_reg;
    logic [W-1:0]     n_reg;
    logic [W-1:0]     b_reg;
    logic [W-1:0]     x_reg;
    logic [W-1:0]     e_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [S_W-1:0]   s_reg;
    logic             done_reg;
    logic             prime_reg;
    logic             triv_reg;
    logic             mul_start_reg;
    logic [W-1:0]     mul_x_reg;
    logic [W-1:0]     mul_y_reg;

    mul_status_t  mul_st;
    logic [W-1:0] mul_res;
    logic [W-1:0] n_minus_one;

    assign n_minus_one = {n_reg[W-1:1], 1'b0};

    mrwt_modmul #(
        .W(W)
    ) u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start_reg),
        .x      (mul_x_reg),
        .y      (mul_y_reg),
        .n      (n_reg),
        .status (mul_st),
        .result (mul_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            b_reg         <= '0;
            x_reg         <= '0;
            e_reg         <= '0;
            cnt_reg       <= '0;
            s_reg         <= '0;
            done_reg      <= 1'b0;
            prime_reg     <= 1'b0;
            triv_reg      <= 1'b0;
            mul_start_reg <= 1'b0;
            mul_x_reg     <= '0;
            mul_y_reg     <= '0;
        end
        else
        begin
            done_reg      <= 1'b0;
            mul_start_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        n_reg <= candidate;
                        b_reg <= witness_base;
                        if (!candidate[0])
                        begin
                            done_reg  <= 1'b1;
                            prime_reg <= (candidate == TWO);
                            triv_reg  <= 1'b1;
                        end
                        else if (candidate == ONE)
                        begin
                            done_reg  <= 1'b1;
                            prime_reg <= 1'b0;
                            triv_reg  <= 1'b1;
                        end
                        else if (candidate == THREE)
                        begin
                            done_reg  <= 1'b1;
                            prime_reg <= 1'b1;
                            triv_reg  <= 1'b1;
                        end
                        else
                        begin
                            e_reg     <= {candidate[W-1:1], 1'b0};
                            s_reg     <= '0;
                            state_reg <= S_STRIP;
                        end
                    end
                end
                S_STRIP:
                begin
                    if (!e_reg[0])
                    begin
                        e_reg <= {1'b0, e_reg[W-1:1]};
                        s_reg <= s_reg + 1'b1;
                    end
                    else
                    begin
                        mul_start_reg <= 1'b1;
                        mul_x_reg     <= ONE;
                        mul_y_reg     <= b_reg;
                        state_reg     <= S_RED;
                    end
                end
                S_RED:
                begin
                    if (mul_st.done)
                    begin
                        b_reg         <= mul_res;
                        x_reg         <= ONE;
                        cnt_reg       <= CNT_W'(W);
                        mul_start_reg <= 1'b1;
                        mul_x_reg     <= ONE;
                        mul_y_reg     <= ONE;
                        state_reg     <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (mul_st.done)
                    begin
                        x_reg <= mul_res;
                        if (e_reg[W-1])
                        begin
                            mul_start_reg <= 1'b1;
                            mul_x_reg     <= mul_res;
                            mul_y_reg     <= b_reg;
                            state_reg     <= S_MB;
                        end
                        else
                        begin
                            state_reg <= S_NEXT;
                        end
                    end
                end
                S_MB:
                begin
                    if (mul_st.done)
                    begin
                        x_reg     <= mul_res;
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    e_reg   <= {e_reg[W-2:0], 1'b0};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_reg <= S_CHK;
                    end
                    else
                    begin
                        mul_start_reg <= 1'b1;
                        mul_x_reg     <= x_reg;
                        mul_y_reg     <= x_reg;
                        state_reg     <= S_SQ;
                    end
                end
                S_CHK:
                begin
                    if ((x_reg == ONE) || (x_reg == n_minus_one))
                    begin
                        done_reg  <= 1'b1;
                        prime_reg <= 1'b1;
                        triv_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                    else if (s_reg == S_W'(1))
                    begin
                        done_reg  <= 1'b1;
                        prime_reg <= 1'b0;
                        triv_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        s_reg         <= s_reg - 1'b1;
                        mul_start_reg <= 1'b1;
                        mul_x_reg     <= x_reg;
                        mul_y_reg     <= x_reg;
                        state_reg     <= S_LSQ;
                    end
                end
                S_LSQ:
                begin
                    if (mul_st.done)
                    begin
                        x_reg <= mul_res;
                        if (mul_res == n_minus_one)
                        begin
                            done_reg  <= 1'b1;
                            prime_reg <= 1'b1;
                            triv_reg  <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else if ((mul_res == ONE) || (s_reg == S_W'(1)))
                        begin
                            done_reg  <= 1'b1;
                            prime_reg <= 1'b0;
                            triv_reg  <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            s_reg         <= s_reg - 1'b1;
                            mul_start_reg <= 1'b1;
                            mul_x_reg     <= mul_res;
                            mul_y_reg     <= mul_res;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy              = (state_reg != S_IDLE);
    assign done              = done_reg;
    assign probably_prime    = prime_reg;
    assign decided_trivially = triv_reg;

`ifndef NO_ASSERTIONS
    a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start_reg |-> !mul_st.busy)
        else $error("Multiplier started while a product was in progress.");

    a_done_frees_block: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && !mul_st.busy)
        else $error("Result shown while work was still in progress.");

    a_even_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !candidate[0]) |=> done && decided_trivially)
        else $error("Even candidate not decided in the next cycle.");

    a_mul_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_st.done && (state_reg == S_IDLE)) |-> 1'b0)
        else $error("Product finished with no item in progress.");
`endif

endmodule
